/* sv/bmalloc_pkg.sv */
// Shared types and constants of the bitmap inode and block allocator.
package bmalloc_pkg;

    // Bitmap storage is organized in words of this many bits
    localparam int WORD_W = 32;
    localparam int POS_W  = 5;

    // Field widths of the request and result items
    localparam int IDX_W = 12;
    localparam int REQ_W = 3;

    // Reset value of the first data block register
    localparam logic [IDX_W-1:0] FDB_RESET = 12'd133;

    // Request codes; the two remaining codes are unknown requests
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC_INODE = 3'd0,
        REQ_ALLOC_BLOCK = 3'd1,
        REQ_FREE_INODE  = 3'd2,
        REQ_FREE_BLOCK  = 3'd3,
        REQ_MARK_INODE  = 3'd4,
        REQ_MARK_BLOCK  = 3'd5
    } req_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_RESP
    } state_t;

    // Outcome of searching one bitmap word for a free bit
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } scan_res_t;

endpackage

/* sv/bmalloc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bmalloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word through the registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bmalloc_word_scan.sv */
// Lowest free bit search over one bitmap word within a number window.
module bmalloc_word_scan #(
    parameter int CW = 8
) (
    input  logic [bmalloc_pkg::WORD_W-1:0] word,
    input  logic [CW-1:0]                  row,
    input  logic [31:0]                    lo,
    input  logic [31:0]                    hi,
    output bmalloc_pkg::scan_res_t         res
);

    // Walk from the top bit down so the lowest candidate wins
    always_comb begin
        logic [31:0] num;
        res = '0;
        num = '0;
        for (int b = bmalloc_pkg::WORD_W - 1; b >= 0; b--) begin
            num = (32'(row) << bmalloc_pkg::POS_W) | 32'(b);
            if (!word[b] && num >= lo && num < hi) begin
                res.hit = 1'b1;
                res.pos = bmalloc_pkg::POS_W'(b);
            end
        end
    end

endmodule

/* sv/bitmap_inode_block_allocator.sv */
// Top level of the first-fit inode and block bitmap allocator.
//
// Two bitmaps (inodes and blocks) live in 32-bit-word RAMs with a registered
// read. After reset the block runs a clearing pass over every word of both
// bitmaps with s_ready low; configuration writes are taken during it. Items are
// handled one at a time. Free and mark requests read, modify and write one
// word; allocations scan one word per cycle through the RAM read port, so an
// inode allocation reads up to ceil(INODE_COUNT/32) words and a block
// allocation up to ceil(BLOCK_COUNT/32) - first_data_block/32 words;
// out-of-range, unknown and empty requests go straight to the result state.
// s_ready is high only in the idle state, entered after the clearing pass and
// after a result has moved to the output register, so an item is not accepted
// before the previous one is done. A new item is accepted while the previous
// result still waits in the output register; while that register is held by
// m_ready low, a finished result waits inside and s_ready stays low.
module bitmap_inode_block_allocator #(
    parameter int INODE_COUNT = 128,
    parameter int BLOCK_COUNT = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bmalloc_pkg::IDX_W-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bmalloc_pkg::REQ_W-1:0]  s_req_type,
    input  logic [bmalloc_pkg::IDX_W-1:0]  s_item_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bmalloc_pkg::IDX_W-1:0]  m_granted_index,
    output logic                           m_found,
    output logic                           m_bad_index
);

    localparam int WW       = bmalloc_pkg::WORD_W;
    localparam int PW       = bmalloc_pkg::POS_W;
    localparam int IW       = bmalloc_pkg::IDX_W;
    localparam int IROWS    = (INODE_COUNT + WW - 1) / WW;
    localparam int BROWS    = (BLOCK_COUNT + WW - 1) / WW;
    localparam int ROWS_MAX = (IROWS > BROWS) ? IROWS : BROWS;
    localparam int CW       = $clog2(ROWS_MAX + 1);
    localparam int IRW      = (IROWS > 1) ? $clog2(IROWS) : 1;
    localparam int BRW      = (BROWS > 1) ? $clog2(BROWS) : 1;

    bmalloc_pkg::state_t state_reg, state_next;
    bmalloc_pkg::req_t   op_reg, op_next;
    logic [CW-1:0]       row_reg, row_next;
    logic [CW-1:0]       last_row_reg, last_row_next;
    logic [CW-1:0]       chk_row_reg, chk_row_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       fdb_reg;
    logic [IW-1:0]       res_granted_reg, res_granted_next;
    logic                res_found_reg, res_found_next;
    logic                res_bad_reg, res_bad_next;
    logic                m_valid_reg, m_valid_next;
    logic [IW-1:0]       m_granted_index_reg, m_granted_index_next;
    logic                m_found_reg, m_found_next;
    logic                m_bad_index_reg, m_bad_index_next;

    logic                i_we, b_we;
    logic [WW-1:0]       i_wdata, b_wdata, i_rdata, b_rdata;
    logic [CW-1:0]       wr_row;
    logic [31:0]         scan_lo, scan_hi;
    logic [WW-1:0]       scan_word;
    bmalloc_pkg::scan_res_t scan_res;

    // Bitmap storage
    bmalloc_ram #(.WIDTH(WW), .DEPTH(IROWS)) u_inode_ram (
        .clk   (aclk),
        .we    (i_we),
        .waddr (wr_row[IRW-1:0]),
        .wdata (i_wdata),
        .raddr (row_reg[IRW-1:0]),
        .rdata (i_rdata)
    );

    bmalloc_ram #(.WIDTH(WW), .DEPTH(BROWS)) u_block_ram (
        .clk   (aclk),
        .we    (b_we),
        .waddr (wr_row[BRW-1:0]),
        .wdata (b_wdata),
        .raddr (row_reg[BRW-1:0]),
        .rdata (b_rdata)
    );

    // Search window for the word that just came out of the RAM
    assign scan_word = (op_reg == bmalloc_pkg::REQ_ALLOC_INODE) ? i_rdata : b_rdata;
    assign scan_lo   = (op_reg == bmalloc_pkg::REQ_ALLOC_BLOCK) ? 32'(fdb_reg) : 32'd0;
    assign scan_hi   = (op_reg == bmalloc_pkg::REQ_ALLOC_INODE) ?
                       32'(INODE_COUNT) : 32'(BLOCK_COUNT);

    bmalloc_word_scan #(.CW(CW)) u_word_scan (
        .word (scan_word),
        .row  (chk_row_reg),
        .lo   (scan_lo),
        .hi   (scan_hi),
        .res  (scan_res)
    );

    assign wr_row = (state_reg == bmalloc_pkg::ST_SCAN) ? chk_row_reg : row_reg;

    // Sequencer: next state, RAM writes and result capture
    always_comb begin
        logic [WW-1:0]      oh;
        logic [31:0]        n_hit;
        bmalloc_pkg::req_t  req;

        state_next           = state_reg;
        op_next              = op_reg;
        row_next             = row_reg;
        last_row_next        = last_row_reg;
        chk_row_next         = chk_row_reg;
        chk_vld_next         = chk_vld_reg;
        idx_next             = idx_reg;
        res_granted_next     = res_granted_reg;
        res_found_next       = res_found_reg;
        res_bad_next         = res_bad_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        m_granted_index_next = m_granted_index_reg;
        m_found_next         = m_found_reg;
        m_bad_index_next     = m_bad_index_reg;
        i_we                 = 1'b0;
        b_we                 = 1'b0;
        i_wdata              = '0;
        b_wdata              = '0;
        s_ready              = 1'b0;
        req                  = bmalloc_pkg::req_t'(s_req_type);
        oh                   = '0;
        n_hit                = (32'(chk_row_reg) << PW) | 32'(scan_res.pos);

        case (state_reg)
            // Zero one word of each bitmap per cycle, as far as that bitmap reaches
            bmalloc_pkg::ST_CLEAR: begin
                i_we = (row_reg < CW'(IROWS));
                b_we = (row_reg < CW'(BROWS));
                if (row_reg == CW'(ROWS_MAX - 1)) begin
                    state_next = bmalloc_pkg::ST_IDLE;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end

            // Take an item and decide how to serve it
            bmalloc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next          = req;
                    idx_next         = s_item_index;
                    res_granted_next = s_item_index;
                    res_found_next   = 1'b0;
                    res_bad_next     = 1'b0;
                    chk_vld_next     = 1'b0;
                    state_next       = bmalloc_pkg::ST_RESP;
                    case (req)
                        bmalloc_pkg::REQ_ALLOC_INODE: begin
                            res_granted_next = '0;
                            row_next         = '0;
                            last_row_next    = CW'(IROWS - 1);
                            state_next       = bmalloc_pkg::ST_SCAN;
                        end
                        bmalloc_pkg::REQ_ALLOC_BLOCK: begin
                            res_granted_next = '0;
                            if (32'(fdb_reg) < 32'(BLOCK_COUNT)) begin
                                row_next      = CW'(fdb_reg >> PW);
                                last_row_next = CW'(BROWS - 1);
                                state_next    = bmalloc_pkg::ST_SCAN;
                            end
                        end
                        bmalloc_pkg::REQ_FREE_INODE, bmalloc_pkg::REQ_MARK_INODE: begin
                            if (32'(s_item_index) < 32'(INODE_COUNT)) begin
                                row_next   = CW'(s_item_index >> PW);
                                state_next = bmalloc_pkg::ST_RMW_RD;
                            end else begin
                                res_bad_next = 1'b1;
                            end
                        end
                        bmalloc_pkg::REQ_FREE_BLOCK, bmalloc_pkg::REQ_MARK_BLOCK: begin
                            if (32'(s_item_index) < 32'(BLOCK_COUNT)) begin
                                row_next   = CW'(s_item_index >> PW);
                                state_next = bmalloc_pkg::ST_RMW_RD;
                            end else begin
                                res_bad_next = 1'b1;
                            end
                        end
                        default: begin
                            res_found_next = 1'b0;
                        end
                    endcase
                end
            end

            // Read one word per cycle, check the word read the cycle before
            bmalloc_pkg::ST_SCAN: begin
                chk_vld_next = (row_reg <= last_row_reg);
                chk_row_next = row_reg;
                if (row_reg <= last_row_reg) begin
                    row_next = row_reg + 1'b1;
                end
                if (chk_vld_reg) begin
                    oh = WW'(1) << scan_res.pos;
                    if (scan_res.hit) begin
                        res_granted_next = n_hit[IW-1:0];
                        res_found_next   = 1'b1;
                        state_next       = bmalloc_pkg::ST_RESP;
                        if (op_reg == bmalloc_pkg::REQ_ALLOC_INODE) begin
                            i_we    = 1'b1;
                            i_wdata = i_rdata | oh;
                            b_we    = (n_hit < 32'(BLOCK_COUNT));
                            b_wdata = b_rdata | oh;
                        end else begin
                            b_we    = 1'b1;
                            b_wdata = b_rdata | oh;
                        end
                    end else if (chk_row_reg == last_row_reg) begin
                        state_next = bmalloc_pkg::ST_RESP;
                    end
                end
            end

            // Address is on the RAM read port this cycle
            bmalloc_pkg::ST_RMW_RD: begin
                state_next = bmalloc_pkg::ST_RMW_WR;
            end

            // Modify the addressed bit and write the word back
            bmalloc_pkg::ST_RMW_WR: begin
                oh             = WW'(1) << idx_reg[PW-1:0];
                res_found_next = 1'b1;
                state_next     = bmalloc_pkg::ST_RESP;
                case (op_reg)
                    bmalloc_pkg::REQ_FREE_INODE: begin
                        i_we    = 1'b1;
                        i_wdata = i_rdata & ~oh;
                        b_we    = (32'(idx_reg) < 32'(BLOCK_COUNT));
                        b_wdata = b_rdata & ~oh;
                    end
                    bmalloc_pkg::REQ_MARK_INODE: begin
                        i_we    = 1'b1;
                        i_wdata = i_rdata | oh;
                    end
                    bmalloc_pkg::REQ_FREE_BLOCK: begin
                        b_we    = 1'b1;
                        b_wdata = b_rdata & ~oh;
                    end
                    bmalloc_pkg::REQ_MARK_BLOCK: begin
                        b_we    = 1'b1;
                        b_wdata = b_rdata | oh;
                    end
                    default: begin
                        res_found_next = 1'b0;
                    end
                endcase
            end

            // Hand the result to the output register once it is free
            bmalloc_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_granted_index_next = res_granted_reg;
                    m_found_next         = res_found_reg;
                    m_bad_index_next     = res_bad_reg;
                    state_next           = bmalloc_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bmalloc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bmalloc_pkg::ST_CLEAR;
            row_reg     <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            fdb_reg     <= bmalloc_pkg::FDB_RESET;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                fdb_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg              <= op_next;
        last_row_reg        <= last_row_next;
        chk_row_reg         <= chk_row_next;
        idx_reg             <= idx_next;
        res_granted_reg     <= res_granted_next;
        res_found_reg       <= res_found_next;
        res_bad_reg         <= res_bad_next;
        m_granted_index_reg <= m_granted_index_next;
        m_found_reg         <= m_found_next;
        m_bad_index_reg     <= m_bad_index_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_granted_index = m_granted_index_reg;
    assign m_found         = m_found_reg;
    assign m_bad_index     = m_bad_index_reg;

endmodule
